### sv/mefr_pkg.sv
package mefr_pkg;

	// Block dimensions.
	localparam int PORT_COUNT  = 6;
	localparam int RING_DEPTH  = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int MEM_DEPTH  = PORT_COUNT * RING_DEPTH;
	localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Line bytes with a meaning of their own.
	localparam logic [7:0] BYTE_ESC   = 8'h40;
	localparam logic [7:0] BYTE_START = 8'h7e;
	localparam logic [7:0] BYTE_END   = 8'h2e;
	localparam logic [7:0] BYTE_H     = 8'h48;
	localparam logic [7:0] ESC_AT     = 8'h41;
	localparam logic [7:0] ESC_TILDE  = 8'h42;
	localparam logic [7:0] ESC_DOT    = 8'h43;
	localparam logic [7:0] ESC_H      = 8'h44;

	// Command field codes.
	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_STORED   = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_END      = 3'd3,
		ST_ABORT    = 3'd4,
		ST_START    = 3'd5,
		ST_DEQUEUED = 3'd6,
		ST_EMPTY    = 3'd7
	} status_t;

	// Request classes decided by the front end.
	typedef enum logic [2:0] {
		OP_IGNORE = 3'd0,
		OP_DEQ    = 3'd1,
		OP_ESC    = 3'd2,
		OP_START  = 3'd3,
		OP_DOT    = 3'd4,
		OP_DATA   = 3'd5
	} op_t;

	// One classified request as it travels from front to back.
	typedef struct packed {
		op_t                   op;
		logic [PORT_IDX_W-1:0] port;
		logic [7:0]            raw;
		logic [7:0]            unesc;
	} item_t;

	// Value of a byte that follows an escape.
	function automatic logic [7:0] unescape(input logic [7:0] b);
		logic [7:0] v;
		v = b;
		if (b == ESC_AT) begin
			v = BYTE_ESC;
		end else if (b == ESC_TILDE) begin
			v = BYTE_START;
		end else if (b == ESC_DOT) begin
			v = BYTE_END;
		end else if (b == ESC_H) begin
			v = BYTE_H;
		end
		return v;
	endfunction

endpackage

### sv/mefr_front.sv
module mefr_front import mefr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [2:0]  port,
	input  logic [7:0]  rx_byte,
	output logic        push,
	output item_t       push_item,
	input  logic        push_ok
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;
	logic  port_ok;
	logic  load;

	// Classify the incoming request.
	always_comb begin
		port_ok       = (4'(port) < 4'(PORT_COUNT));
		item_c.port   = port[PORT_IDX_W-1:0];
		item_c.raw    = rx_byte;
		item_c.unesc  = unescape(rx_byte);
		if (!port_ok) begin
			item_c.op = OP_IGNORE;
		end else if (command == CMD_DEQUEUE) begin
			item_c.op = OP_DEQ;
		end else if (rx_byte == BYTE_ESC) begin
			item_c.op = OP_ESC;
		end else if (rx_byte == BYTE_START) begin
			item_c.op = OP_START;
		end else if (rx_byte == BYTE_END) begin
			item_c.op = OP_DOT;
		end else begin
			item_c.op = OP_DATA;
		end
	end

	// The stage holds only when the queue cannot take its request.
	assign in_stall  = valid_s1 && !push_ok;
	assign load      = in_valid && !in_stall;
	assign push      = valid_s1 && push_ok;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !push_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_c;
		end
	end

endmodule

### sv/mefr_queue.sv
module mefr_queue import mefr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  push_ok,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign push_ok    = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

### sv/mefr_back.sv
module mefr_back import mefr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] data_out,
	output logic [7:0] frames_ready
);

	// Per-port protocol state.
	logic             active_q [PORT_COUNT];
	logic             esc_q    [PORT_COUNT];
	logic [7:0]       count_q  [PORT_COUNT];
	logic [PTR_W-1:0] wr_q     [PORT_COUNT];
	logic [PTR_W-1:0] rd_q     [PORT_COUNT];

	// Ring storage shared by all ports.
	logic [7:0]       ring_mem [MEM_DEPTH];
	logic [7:0]       rdata_q;

	// Result register.
	logic             valid_s2;
	status_t          status_s2;
	logic [7:0]       data_s2;
	logic [7:0]       frames_s2;
	logic             deq_s2;

	// Current port state and its update.
	logic             cur_active;
	logic             cur_esc;
	logic [7:0]       cur_count;
	logic [PTR_W-1:0] cur_wr;
	logic [PTR_W-1:0] cur_rd;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;
	logic             nxt_active;
	logic             nxt_esc;
	logic [7:0]       nxt_count;
	logic [PTR_W-1:0] nxt_wr;
	logic [PTR_W-1:0] nxt_rd;
	logic             upd;
	status_t          res_status;
	logic [7:0]       res_data;
	logic [7:0]       res_frames;
	logic             res_deq;
	logic             mem_we;
	logic             mem_re;
	logic [PTR_W-1:0] mem_ptr;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]       store_val;

	assign pop = head_valid && (!valid_s2 || !out_stall);

	always_comb begin
		cur_active = active_q[head.port];
		cur_esc    = esc_q[head.port];
		cur_count  = count_q[head.port];
		cur_wr     = wr_q[head.port];
		cur_rd     = rd_q[head.port];
		wr_next    = (cur_wr == PTR_W'(RING_DEPTH - 1)) ? '0 : cur_wr + 1'b1;
		rd_next    = (cur_rd == PTR_W'(RING_DEPTH - 1)) ? '0 : cur_rd + 1'b1;
		store_val  = cur_esc ? head.unesc : head.raw;
	end

	// Each port owns one contiguous block of the ring memory.
	assign mem_addr = ADDR_W'(head.port) * ADDR_W'(RING_DEPTH) + ADDR_W'(mem_ptr);

	// Execute one request against the addressed port.
	always_comb begin
		nxt_active = cur_active;
		nxt_esc    = cur_esc;
		nxt_count  = cur_count;
		nxt_wr     = cur_wr;
		nxt_rd     = cur_rd;
		upd        = 1'b0;
		res_status = ST_IGNORED;
		res_data   = '0;
		res_frames = cur_count;
		res_deq    = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_ptr    = cur_wr;
		unique case (head.op)
			OP_IGNORE: begin
				res_frames = '0;
			end
			OP_DEQ: begin
				mem_ptr = cur_rd;
				if (cur_rd == cur_wr) begin
					res_status = ST_EMPTY;
				end else begin
					res_status = ST_DEQUEUED;
					res_deq    = 1'b1;
					mem_re     = 1'b1;
					nxt_rd     = rd_next;
					upd        = 1'b1;
				end
			end
			OP_ESC: begin
				nxt_esc = 1'b1;
				upd     = 1'b1;
			end
			OP_START: begin
				upd        = 1'b1;
				nxt_active = 1'b1;
				if (cur_active) begin
					nxt_esc    = 1'b0;
					nxt_wr     = '0;
					nxt_rd     = '0;
					res_status = ST_ABORT;
				end else begin
					res_status = ST_START;
				end
			end
			OP_DOT: begin
				if (cur_active) begin
					upd        = 1'b1;
					nxt_active = 1'b0;
					nxt_count  = cur_count + 1'b1;
					res_frames = cur_count + 1'b1;
					res_status = ST_END;
				end
			end
			OP_DATA: begin
				if (cur_active) begin
					upd     = 1'b1;
					nxt_esc = 1'b0;
					if (wr_next == cur_rd) begin
						res_status = ST_DROPPED;
					end else begin
						res_status = ST_STORED;
						res_data   = store_val;
						mem_we     = 1'b1;
						nxt_wr     = wr_next;
					end
				end
			end
			default: begin
				res_frames = '0;
			end
		endcase
	end

	// Port state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_COUNT; i++) begin
				active_q[i] <= 1'b0;
				esc_q[i]    <= 1'b0;
				count_q[i]  <= '0;
				wr_q[i]     <= '0;
				rd_q[i]     <= '0;
			end
		end else if (pop && upd) begin
			active_q[head.port] <= nxt_active;
			esc_q[head.port]    <= nxt_esc;
			count_q[head.port]  <= nxt_count;
			wr_q[head.port]     <= nxt_wr;
			rd_q[head.port]     <= nxt_rd;
		end
	end

	// Ring write and registered read.
	always_ff @(posedge clk) begin
		if (pop && mem_we) begin
			ring_mem[mem_addr] <= store_val;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && mem_re) begin
			rdata_q <= ring_mem[mem_addr];
		end
	end

	// Result register, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_s2 <= res_status;
			data_s2   <= res_data;
			frames_s2 <= res_frames;
			deq_s2    <= res_deq;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = status_s2;
	assign data_out     = deq_s2 ? rdata_q : data_s2;
	assign frames_ready = frames_s2;

	// A request is never taken while a stalled result is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(valid_s2 && out_stall))
		else $error("request taken over a stalled result");

	// A port out of range reports zero frames.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op == OP_IGNORE |=> status_s2 == ST_IGNORED && frames_s2 == '0)
		else $error("ignored request changed the result");

	// A dequeue from a ring that holds data returns a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op == OP_DEQ && cur_rd != cur_wr |=> deq_s2 && status_s2 == ST_DEQUEUED)
		else $error("dequeue from a non-empty ring not reported");

	// Data bytes outside a frame are never stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op == OP_DATA && !cur_active |=> status_s2 == ST_IGNORED)
		else $error("byte outside a frame was handled");

endmodule

### sv/multiport_escaped_frame_receiver.sv
// Byte-stuffed frame receiver for several serial ports.
//
// Requests enter on in_valid/in_stall with command, port and rx_byte. A
// receive command feeds one line byte to the addressed port's deframer; a
// dequeue command pops one decoded byte from that port's ring. Every request
// gives exactly one result on out_valid/out_stall: status, data_out and
// frames_ready, in request order.
//
// An accepted request passes through the classify stage register and the
// small request queue, then the execute stage writes the result register.
// Throughput is one request per cycle while out_stall is low, set by
// the per-port state update and the single-port ring memory, which takes
// one write or one read each cycle.
//
// Reset clears all frame flags, escape flags, frame counters and ring
// pointers at once; ring contents are not cleared and need no sweep.
// When the receiver stalls, the result is held, the queue fills, and after
// its four entries and the classify stage are full, in_stall rises.
module multiport_escaped_frame_receiver import mefr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [2:0] port,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] data_out,
	output logic [7:0] frames_ready
);

	logic  push;
	logic  push_ok;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head;

	// Classify stage.
	mefr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.port      (port),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_item (push_item),
		.push_ok   (push_ok)
	);

	// Request queue between the two halves.
	mefr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ok    (push_ok),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Execute stage with port state and ring memory.
	mefr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.data_out     (data_out),
		.frames_ready (frames_ready)
	);

endmodule

### sim/tb.sv
module tb;
	import mefr_pkg::*;

	// One decoded result as the block reports it.
	typedef struct packed {
		status_t    st;
		logic [7:0] data;
		logic [7:0] frames;
	} rx_result_t;

	// One row of the directed stimulus; typed rows carry their own expected result.
	typedef struct packed {
		logic       cmd;
		logic [2:0] port;
		logic [7:0] rx;
		bit         typed;
		rx_result_t res;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       command;
	logic [2:0] port;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	logic [7:0] data_out;
	logic [7:0] frames_ready;

	// Shadow copy of the per-port deframer state.
	bit         frame_open [PORT_COUNT];
	bit         esc_armed [PORT_COUNT];
	logic [7:0] done_frames [PORT_COUNT];
	logic [7:0] ring_mem [PORT_COUNT][RING_DEPTH];
	int         wr_ptr [PORT_COUNT];
	int         rd_ptr [PORT_COUNT];
	bit         count_wrapped;

	rx_result_t expected_results [$];
	int         mismatch_count;
	int         accepted_count;
	bit         calm_in;

	multiport_escaped_frame_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.port         (port),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.data_out     (data_out),
		.frames_ready (frames_ready)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog for a hung handshake.
	initial begin
		#12000000;
		$display("[multiport_escaped_frame_receiver] ERROR");
		$finish;
	end

	// Computes the result of one request and advances the shadow state.
	function automatic rx_result_t predict_frame_step(input logic cmd, input logic [2:0] p,
			input logic [7:0] rx);
		rx_result_t r;
		logic [7:0] v;
		int         nxt;
		r.st = ST_IGNORED;
		r.data = 8'h00;
		r.frames = 8'h00;
		if (p >= PORT_COUNT) begin
			return r;
		end
		if (cmd == CMD_DEQUEUE) begin
			if (rd_ptr[p] == wr_ptr[p]) begin
				r.st = ST_EMPTY;
			end else begin
				r.data = ring_mem[p][rd_ptr[p]];
				rd_ptr[p] = (rd_ptr[p] + 1) % RING_DEPTH;
				r.st = ST_DEQUEUED;
			end
		end else if (rx == BYTE_ESC) begin
			esc_armed[p] = 1'b1;
		end else if (rx == BYTE_START) begin
			// A second start throws away the partial frame but keeps it open.
			if (frame_open[p]) begin
				esc_armed[p] = 1'b0;
				wr_ptr[p] = 0;
				rd_ptr[p] = 0;
				r.st = ST_ABORT;
			end else begin
				r.st = ST_START;
			end
			frame_open[p] = 1'b1;
		end else if (frame_open[p] && rx == BYTE_END) begin
			done_frames[p] = done_frames[p] + 8'd1;
			if (done_frames[p] == 8'd0) begin
				count_wrapped = 1'b1;
			end
			frame_open[p] = 1'b0;
			r.st = ST_END;
		end else if (frame_open[p]) begin
			v = rx;
			if (esc_armed[p]) begin
				case (rx)
					ESC_AT:    v = BYTE_ESC;
					ESC_TILDE: v = BYTE_START;
					ESC_DOT:   v = BYTE_END;
					ESC_H:     v = BYTE_H;
					default:   v = rx;
				endcase
				esc_armed[p] = 1'b0;
			end
			// The ring keeps one slot free to tell full from empty.
			nxt = (wr_ptr[p] + 1) % RING_DEPTH;
			if (nxt == rd_ptr[p]) begin
				r.st = ST_DROPPED;
			end else begin
				ring_mem[p][wr_ptr[p]] = v;
				wr_ptr[p] = nxt;
				r.st = ST_STORED;
				r.data = v;
			end
		end
		r.frames = done_frames[p];
		return r;
	endfunction

	// Counts one mismatch and prints it while no more than 50 have been seen.
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
	endtask

	// Compares one accepted result against the oldest outstanding expectation.
	task automatic check_result();
		rx_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with no request outstanding, status %0d", status));
		end else begin
			want = expected_results.pop_front();
			if (status !== want.st) begin
				report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
			end
			if (data_out !== want.data) begin
				report_mismatch($sformatf("data_out %02h, wanted %02h", data_out, want.data));
			end
			if (frames_ready !== want.frames) begin
				report_mismatch($sformatf("frames_ready %0d, wanted %0d", frames_ready,
					want.frames));
			end
		end
	endtask

	// Presents one request after a random gap and waits until it is taken.
	task automatic send_request(input logic cmd, input logic [2:0] p, input logic [7:0] rx,
			input bit typed, input rx_result_t typed_res);
		int         gap;
		int         r;
		rx_result_t predicted;
		r = $urandom_range(0, 99);
		if (calm_in || r < 60) begin
			gap = 0;
		end else if (r < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 30);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		port <= p;
		rx_byte <= rx;
		do @(posedge clk); while (in_stall);
		predicted = predict_frame_step(cmd, p, rx);
		expected_results.push_back(typed ? typed_res : predicted);
		if (p < PORT_COUNT) begin
			accepted_count++;
		end
	endtask

	// Random byte that carries no framing meaning of its own.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == BYTE_ESC || b == BYTE_START || b == BYTE_END) begin
			b = b ^ 8'h01;
		end
		return b;
	endfunction

	// Sends a frame body: plain bytes mixed with escape pairs.
	task automatic send_payload(input logic [2:0] p, input int len);
		rx_result_t none;
		none = '0;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < 15) begin
				send_request(CMD_RECEIVE, p, BYTE_ESC, 1'b0, none);
				if ($urandom_range(0, 3) != 0) begin
					send_request(CMD_RECEIVE, p, ESC_AT + 8'($urandom_range(0, 3)), 1'b0, none);
				end else begin
					send_request(CMD_RECEIVE, p, plain_byte(), 1'b0, none);
				end
			end else begin
				send_request(CMD_RECEIVE, p, plain_byte(), 1'b0, none);
			end
		end
	endtask

	// Result side: checks accepted results and stalls at random.
	initial begin
		int stall_left;
		int cyc;
		bit calm_out;
		stall_left = 0;
		cyc = 0;
		calm_out = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				check_result();
			end
			cyc++;
			if (cyc % 256 == 0) begin
				calm_out = ($urandom_range(0, 3) == 0);
			end
			if (stall_left == 0 && !calm_out && $urandom_range(0, 99) < 25) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
					: $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Request side: reset, directed table, then random sequences.
	initial begin
		stim_row_t  stim_table [$];
		rx_result_t none;
		int         kind;
		int         len;
		logic [2:0] p;
		logic [7:0] b;
		none = '0;
		mismatch_count = 0;
		accepted_count = 0;
		count_wrapped = 1'b0;
		calm_in = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_RECEIVE;
		port <= 3'd0;
		rx_byte <= 8'h00;
		for (int i = 0; i < PORT_COUNT; i++) begin
			frame_open[i] = 1'b0;
			esc_armed[i] = 1'b0;
			done_frames[i] = 8'h00;
			wr_ptr[i] = 0;
			rd_ptr[i] = 0;
		end

		// Directed rows: command, port, byte, typed flag, expected result.
		stim_table.push_back(stim_row_t'{CMD_DEQUEUE, 3'd0, 8'h00, 1'b1, {ST_EMPTY, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd7, 8'hff, 1'b1, {ST_IGNORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_DEQUEUE, 3'd6, 8'ha5, 1'b1, {ST_IGNORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, 8'h00, 1'b1, {ST_IGNORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_END, 1'b1,
			{ST_IGNORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_START, 1'b1,
			{ST_START, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, 8'h00, 1'b1, {ST_STORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, 8'hff, 1'b1, {ST_STORED, 8'hff, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_ESC, 1'b1,
			{ST_IGNORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, ESC_AT, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_ESC, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, ESC_TILDE, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_ESC, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, ESC_DOT, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_ESC, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, ESC_H, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_ESC, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, 8'h7f, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_END, 1'b1, {ST_END, 8'h00, 8'd1}});
		stim_table.push_back(stim_row_t'{CMD_DEQUEUE, 3'd1, 8'h5a, 1'b1,
			{ST_DEQUEUED, 8'h00, 8'd1}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_START, 1'b1,
			{ST_START, 8'h00, 8'd1}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_ESC, 1'b0, none});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd1, BYTE_START, 1'b1,
			{ST_ABORT, 8'h00, 8'd1}});
		stim_table.push_back(stim_row_t'{CMD_DEQUEUE, 3'd1, 8'h00, 1'b1, {ST_EMPTY, 8'h00, 8'd1}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd5, BYTE_ESC, 1'b1,
			{ST_IGNORED, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd5, BYTE_START, 1'b1,
			{ST_START, 8'h00, 8'd0}});
		stim_table.push_back(stim_row_t'{CMD_RECEIVE, 3'd5, ESC_TILDE, 1'b0, none});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			send_request(stim_table[i].cmd, stim_table[i].port, stim_table[i].rx,
				stim_table[i].typed, stim_table[i].res);
		end

		// Random sequences, mostly well-formed frames with random content.
		while ((accepted_count < 1200 || !count_wrapped) && accepted_count < 4000) begin
			calm_in = ($urandom_range(0, 9) == 0);
			kind = $urandom_range(0, 99);
			p = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, PORT_COUNT - 1));
			if (kind < 40) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 8);
				send_request(CMD_RECEIVE, p, BYTE_START, 1'b0, none);
				send_payload(p, len);
				send_request(CMD_RECEIVE, p, BYTE_END, 1'b0, none);
			end else if (kind < 50) begin
				// Frame left open; the next start on this port aborts it.
				send_request(CMD_RECEIVE, p, BYTE_START, 1'b0, none);
				send_payload(p, $urandom_range(0, 6));
			end else if (kind < 62) begin
				// Runs of empty frames drive a counter through its wrap.
				if ($urandom_range(0, 3) != 0) begin
					p = 3'd0;
				end
				len = $urandom_range(20, 50);
				for (int k = 0; k < len; k++) begin
					send_request(CMD_RECEIVE, p, BYTE_START, 1'b0, none);
					send_request(CMD_RECEIVE, p, BYTE_END, 1'b0, none);
				end
			end else if (kind < 82) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					send_request(CMD_DEQUEUE, p, 8'($urandom_range(0, 255)), 1'b0, none);
				end
			end else begin
				// Noise: any command, any port, framing bytes favored.
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 7))
						0: b = BYTE_ESC;
						1: b = BYTE_START;
						2: b = BYTE_END;
						3: b = ESC_AT + 8'($urandom_range(0, 3));
						default: b = 8'($urandom_range(0, 255));
					endcase
					send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), b, 1'b0, none);
				end
			end
		end
		in_valid <= 1'b0;

		// Drain the outstanding results, then watch for strays.
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[multiport_escaped_frame_receiver] OK");
		end else begin
			$display("[multiport_escaped_frame_receiver] ERROR");
		end
		$finish;
	end

endmodule
